>>> rtl/core/amrb_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// amrb_pkg
// Shared constants, types and helpers for the audio mix ring buffer core.
// ============================================================================
package amrb_pkg;

    localparam int RING_DEPTH = 32768;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int CFG_W      = 15;
    localparam int CMP_W      = (PTR_W > CFG_W) ? PTR_W : CFG_W;
    localparam int CHAN_W     = 8;
    localparam int SUM_W      = 11;
    localparam int SAMPLE_W   = 16;
    localparam int FILL_OUT_W = 15;

    localparam logic [CFG_W-1:0] PREFILL_RESET = 15'd8192;

    // Divide by five: floor(x * 1639 / 8192) is exact for x up to 1275
    localparam int              MIX_SHIFT = 13;
    localparam int              PROD_W    = 22;
    localparam logic [10:0]     MIX_RECIP = 11'd1639;
    localparam logic [8:0]      MIX_BIAS  = 9'd128;

    localparam logic signed [16:0] SAT_HI = 17'sd32767;
    localparam logic signed [16:0] SAT_LO = -17'sd32768;

    localparam logic [1:0] KIND_PUSH   = 2'd0;
    localparam logic [1:0] KIND_PULL   = 2'd1;
    localparam logic [1:0] KIND_REOPEN = 2'd2;
    localparam logic [1:0] KIND_FLUSH  = 2'd3;

    typedef logic [PTR_W-1:0] ptr_t;

    typedef struct packed {
        logic capture;
        logic mix;
        logic scale;
        logic push;
        logic pull;
        logic pop;
        logic reopen;
        logic flush;
    } amrb_cmd_t;

    typedef struct packed {
        logic pop_go;
    } amrb_status_t;

    function automatic ptr_t ptr_inc(input ptr_t p);
        if (p == PTR_W'(RING_DEPTH - 1))
            return '0;
        else
            return p + 1'b1;
    endfunction

    function automatic ptr_t ring_fill(input ptr_t wp, input ptr_t rp);
        logic [PTR_W:0] wide;
        wide = {1'b0, wp} + (PTR_W + 1)'(RING_DEPTH) - {1'b0, rp};
        if (wp >= rp)
            return wp - rp;
        else
            return wide[PTR_W-1:0];
    endfunction

endpackage

>>> rtl/core/audio_mix_ring_buffer_core.sv
`timescale 1ns / 1ps
// ============================================================================
// audio_mix_ring_buffer_core
// Audio sample FIFO that mixes five channels on push and gates pulls on prefill.
// A push runs the mix, scale and push states; a pull runs the pull state and,
// when a sample is popped, the pop state, which takes the registered ring read;
// reopen and flush the control state. All end in done; busy drops the cycle after.
// Reset clears pointers, playback flag and held sample and sets prefill to 8192;
// the ring contents are not cleared. The receiver cannot stall results.
// ============================================================================
module audio_mix_ring_buffer_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         kind,
    input  logic [7:0]         chan_a,
    input  logic [7:0]         chan_b,
    input  logic [7:0]         chan_c,
    input  logic [7:0]         chan_d,
    input  logic [7:0]         chan_e,
    input  logic               cfg_wr_en,
    input  logic [14:0]        cfg_wr_data,
    output logic               done,
    output logic signed [15:0] sample,
    output logic               dropped,
    output logic               underrun,
    output logic               playing,
    output logic [14:0]        fill_level
);
    import amrb_pkg::*;

    amrb_cmd_t    cmd;
    amrb_status_t status;

    amrb_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .kind   (kind),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    amrb_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .chan_a      (chan_a),
        .chan_b      (chan_b),
        .chan_c      (chan_c),
        .chan_d      (chan_d),
        .chan_e      (chan_e),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .sample      (sample),
        .dropped     (dropped),
        .underrun    (underrun),
        .playing     (playing),
        .fill_level  (fill_level)
    );

endmodule

>>> rtl/core/amrb_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// amrb_ctrl
// Sequencer for the audio mix ring buffer: one command at a time.
// ============================================================================
module amrb_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [1:0]            kind,
    input  amrb_pkg::amrb_status_t status,
    output amrb_pkg::amrb_cmd_t   cmd,
    output logic                  busy,
    output logic                  done
);
    import amrb_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_MIX   = 8'b0000_0010,
        ST_SCALE = 8'b0000_0100,
        ST_PUSH  = 8'b0000_1000,
        ST_PULL  = 8'b0001_0000,
        ST_POP   = 8'b0010_0000,
        ST_CTRL  = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [1:0] kind_reg;
    logic [1:0] kind_next;
    logic       accept;

    assign accept = start && (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    kind_next = kind;
                    case (kind)
                        KIND_PUSH: state_next = ST_MIX;
                        KIND_PULL: state_next = ST_PULL;
                        default:   state_next = ST_CTRL;
                    endcase
                end
            end
            ST_MIX:   state_next = ST_SCALE;
            ST_SCALE: state_next = ST_PUSH;
            ST_PUSH:  state_next = ST_DONE;
            ST_PULL:  state_next = status.pop_go ? ST_POP : ST_DONE;
            ST_POP:   state_next = ST_DONE;
            ST_CTRL:  state_next = ST_DONE;
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            kind_reg  <= KIND_PUSH;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    always_comb
    begin
        cmd         = '0;
        cmd.capture = accept;
        cmd.mix     = (state_reg == ST_MIX);
        cmd.scale   = (state_reg == ST_SCALE);
        cmd.push    = (state_reg == ST_PUSH);
        cmd.pull    = (state_reg == ST_PULL);
        cmd.pop     = (state_reg == ST_POP);
        cmd.reopen  = (state_reg == ST_CTRL) && (kind_reg == KIND_REOPEN);
        cmd.flush   = (state_reg == ST_CTRL) && (kind_reg == KIND_FLUSH);
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result beat longer than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy && !done)
        else $error("accepted beat did not start work");

    a_pop_after_pull: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> $past(cmd.pull) && $past(status.pop_go))
        else $error("pop without a pull that found data");

endmodule

>>> rtl/core/amrb_datapath.sv
`timescale 1ns / 1ps
// ============================================================================
// amrb_datapath
// Mixer, ring store, pointers, playback flag and result registers.
// ============================================================================
module amrb_datapath
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  amrb_pkg::amrb_cmd_t          cmd,
    output amrb_pkg::amrb_status_t       status,
    input  logic [7:0]                   chan_a,
    input  logic [7:0]                   chan_b,
    input  logic [7:0]                   chan_c,
    input  logic [7:0]                   chan_d,
    input  logic [7:0]                   chan_e,
    input  logic                         cfg_wr_en,
    input  logic [14:0]                  cfg_wr_data,
    output logic signed [15:0]           sample,
    output logic                         dropped,
    output logic                         underrun,
    output logic                         playing,
    output logic [14:0]                  fill_level
);
    import amrb_pkg::*;

    logic [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
    logic [SAMPLE_W-1:0] rd_data_reg;

    ptr_t                rd_ptr_reg;
    ptr_t                wr_ptr_reg;
    logic                started_reg;
    logic [SAMPLE_W-1:0] held_reg;
    logic [CFG_W-1:0]    prefill_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [CHAN_W-1:0]   quot_reg;
    logic [SAMPLE_W-1:0] mixed_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic                dropped_reg;
    logic                underrun_reg;

    logic [SUM_W-1:0]    sum_next;
    logic [PROD_W-1:0]   prod;
    logic signed [16:0]  diff;
    logic signed [16:0]  scaled;
    logic [SAMPLE_W-1:0] sat_next;
    ptr_t                fill;
    logic                full;
    logic                empty;
    logic                started_next;
    logic                mem_we;
    logic                mem_re;

    assign sum_next = SUM_W'(chan_a) + SUM_W'(chan_b) + SUM_W'(chan_c)
                    + SUM_W'(chan_d) + SUM_W'(chan_e);
    assign prod     = PROD_W'(sum_reg) * PROD_W'(MIX_RECIP);
    assign diff     = 17'(signed'({1'b0, quot_reg})) - 17'(signed'({1'b0, MIX_BIAS}));
    assign scaled   = (diff <<< 8) + (diff <<< 7);

    always_comb
    begin
        if (scaled > SAT_HI)
            sat_next = SAT_HI[SAMPLE_W-1:0];
        else if (scaled < SAT_LO)
            sat_next = SAT_LO[SAMPLE_W-1:0];
        else
            sat_next = scaled[SAMPLE_W-1:0];
    end

    assign fill         = ring_fill(wr_ptr_reg, rd_ptr_reg);
    assign full         = (ptr_inc(wr_ptr_reg) == rd_ptr_reg);
    assign empty        = (wr_ptr_reg == rd_ptr_reg);
    assign started_next = started_reg || (CMP_W'(fill) >= CMP_W'(prefill_reg));
    assign status.pop_go = started_next && !empty;

    assign mem_we = cmd.push && !full;
    assign mem_re = cmd.pull && status.pop_go;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            ring_mem[wr_ptr_reg] <= mixed_reg;
        if (mem_re)
            rd_data_reg <= ring_mem[rd_ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            sum_reg <= sum_next;
        if (cmd.mix)
            quot_reg <= prod[MIX_SHIFT +: CHAN_W];
        if (cmd.scale)
            mixed_reg <= sat_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prefill_reg <= PREFILL_RESET;
        else if (cfg_wr_en)
            prefill_reg <= cfg_wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg   <= '0;
            wr_ptr_reg   <= '0;
            started_reg  <= 1'b0;
            held_reg     <= '0;
            sample_reg   <= '0;
            dropped_reg  <= 1'b0;
            underrun_reg <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                sample_reg   <= '0;
                dropped_reg  <= 1'b0;
                underrun_reg <= 1'b0;
            end
            if (cmd.push)
            begin
                if (full)
                    dropped_reg <= 1'b1;
                else
                    wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (cmd.pull)
            begin
                started_reg <= started_next;
                if (mem_re)
                    rd_ptr_reg <= ptr_inc(rd_ptr_reg);
                else if (started_next)
                begin
                    underrun_reg <= 1'b1;
                    sample_reg   <= held_reg;
                end
            end
            if (cmd.pop)
            begin
                held_reg   <= rd_data_reg;
                sample_reg <= rd_data_reg;
            end
            if (cmd.reopen)
            begin
                rd_ptr_reg  <= '0;
                wr_ptr_reg  <= '0;
                started_reg <= 1'b0;
                held_reg    <= '0;
            end
            if (cmd.flush)
            begin
                rd_ptr_reg <= '0;
                wr_ptr_reg <= '0;
            end
        end
    end

    assign sample     = signed'(sample_reg);
    assign dropped    = dropped_reg;
    assign underrun   = underrun_reg;
    assign playing    = started_reg;
    assign fill_level = FILL_OUT_W'(fill);

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(rd_ptr_reg) < RING_DEPTH) && (32'(wr_ptr_reg) < RING_DEPTH))
        else $error("ring pointer out of range");

    a_started_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(started_reg) |-> $past(cmd.reopen))
        else $error("playback stopped without reopen");

endmodule
